// ===== design/nds_pkg.sv =====
// ---------------------------------------------------------------------------
// nds_pkg: shared types and constants of the neighbor discovery scheduler
// Holds the beat structs, the sequencer states, result codes and the
// configuration register map with its reset values.
// ---------------------------------------------------------------------------
package nds_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_OP_MODE        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_EPOCH_PHASES   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BURST_BEACONS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_SPACING = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BEACON_WINDOW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_WINDOW  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LISTEN_SLICE   = 3'd6;

  localparam logic        RST_OP_MODE        = 1'b0;
  localparam logic [15:0] RST_EPOCH_PHASES   = 16'd100;
  localparam logic [15:0] RST_BURST_BEACONS  = 16'd10;
  localparam logic [23:0] RST_BEACON_SPACING = 24'd328;
  localparam logic [23:0] RST_BEACON_WINDOW  = 24'd3277;
  localparam logic [23:0] RST_LISTEN_WINDOW  = 24'd3277;
  localparam logic [23:0] RST_LISTEN_SLICE   = 24'd328;

  // Operating modes and input opcodes
  localparam logic MODE_BURST   = 1'b0;
  localparam logic MODE_SCATTER = 1'b1;
  localparam logic OP_STEP      = 1'b0;
  localparam logic OP_RECEIVE   = 1'b1;

  // Result kinds
  localparam logic [1:0] KIND_PHASE    = 2'd0;
  localparam logic [1:0] KIND_NEIGHBOR = 2'd1;
  localparam logic [1:0] KIND_EPOCH    = 2'd2;

  // Radio actions
  localparam logic [1:0] ACT_NONE   = 2'd0;
  localparam logic [1:0] ACT_BEACON = 2'd1;
  localparam logic [1:0] ACT_ON     = 2'd2;
  localparam logic [1:0] ACT_OFF    = 2'd3;

  // Phase kinds inside the sequence
  localparam logic [1:0] PK_SEND   = 2'd0;
  localparam logic [1:0] PK_LISTEN = 2'd1;
  localparam logic [1:0] PK_END    = 2'd2;
  localparam logic [1:0] PH_UNUSED = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_PHASE,
    ST_SEARCH,
    ST_NEW
  } nds_state_t;

  typedef struct packed {
    logic        op;
    logic        id_ok;
    logic [15:0] neighbor_id;
  } nds_in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  action;
    logic [23:0] wait_ticks;
    logic [15:0] epoch_number;
    logic [15:0] found_id;
    logic [6:0]  found_count;
    logic        table_full;
    logic        last;
  } nds_out_t;

endpackage

// ===== design/nds_table.sv =====
// ---------------------------------------------------------------------------
// nds_table: table of neighbor ids found in the current epoch
// Single write port and one registered read port; the read valid flag
// follows the read enable in the next cycle so the search can compare in flight.
// ---------------------------------------------------------------------------
module nds_table
  import nds_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  output logic              rd_valid
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;
  logic             rd_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_valid_r <= 1'b0;
    end else begin
      rd_valid_r <= rd_en;
    end
  end

  assign rd_data  = rd_data_r;
  assign rd_valid = rd_valid_r;

endmodule

// ===== design/neighbor_discovery_duty_scheduler_unit.sv =====
// ---------------------------------------------------------------------------
// neighbor_discovery_duty_scheduler_unit: radio duty-cycle scheduler
// Steps the radio through burst or scatter phases, closes epochs and keeps
// the table of neighbors discovered in the current epoch.
// ---------------------------------------------------------------------------
// Usage: raise start with a beat on in_data while busy is low. A timer step
// (op 0) returns a phase action through the step state and the output
// register; when the epoch is due, an epoch-end beat comes first and the
// phase beat in the cycle after it. A received packet (op 1) with id_ok set
// searches the table one entry per cycle through the registered read port,
// so the new-neighbor beat follows once every stored entry has been compared.
// A duplicate or a bad packet gives no beat; a bad one never raises busy.
// busy stays high until the last beat of the item is registered, so one item
// is handled at a time. Each result is shown for one cycle with out_valid;
// the receiver cannot stall and must take it. Configuration writes through
// cfg_we/cfg_index/cfg_wdata take effect at once and belong to idle time.
// Reset (rst_n low, synchronous) restores the register defaults, clears the
// counters and empties the table; no clearing pass over the table is needed.
// ---------------------------------------------------------------------------
module neighbor_discovery_duty_scheduler_unit
  import nds_pkg::*;
#(
  parameter int MAX_NEIGHBORS = 64,
  parameter int ID_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  nds_in_t               in_data,
  output logic                  out_valid,
  output nds_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CNT_W  = $clog2(MAX_NEIGHBORS + 1);
  localparam int ADDR_W = (MAX_NEIGHBORS > 1) ? $clog2(MAX_NEIGHBORS) : 1;
  localparam int ID_W   = (ID_BITS < 16) ? ID_BITS : 16;
  localparam logic [CNT_W-1:0] TABLE_FULL_CNT = CNT_W'(MAX_NEIGHBORS);

  // Configuration registers
  logic        op_mode_r;
  logic [15:0] epoch_phases_r;
  logic [15:0] burst_beacons_r;
  logic [23:0] beacon_spacing_r;
  logic [23:0] beacon_window_r;
  logic [23:0] listen_window_r;
  logic [23:0] listen_slice_r;

  // Scheduler state
  nds_state_t       state_r, state_nxt;
  logic [1:0]       phase_index_r, phase_index_nxt;
  logic [15:0]      beacons_left_r, beacons_left_nxt;
  logic [15:0]      phases_done_r, phases_done_nxt;
  logic [15:0]      epoch_counter_r, epoch_counter_nxt;
  logic [CNT_W-1:0] found_total_r, found_total_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic [ID_W-1:0]  id_r, id_nxt;
  logic             out_valid_r, out_valid_nxt;
  nds_out_t         out_data_r, out_data_nxt;

  logic            accept;
  logic            epoch_due;
  logic            burst;
  logic [15:0]     reload_val;
  logic            hit;
  logic            tbl_wr_en;
  logic            tbl_rd_en;
  logic [ID_W-1:0] tbl_rd_data;
  logic            tbl_rd_valid;

  // Phase unit outputs
  logic [1:0]  ph_kind;
  logic [1:0]  ph_index;
  logic [15:0] ph_beacons;
  logic        ph_count;
  logic [1:0]  ph_action;
  logic [23:0] ph_wait;

  assign accept     = start && (state_r == ST_IDLE);
  assign busy       = (state_r != ST_IDLE);
  assign epoch_due  = (phases_done_r == epoch_phases_r);
  assign burst      = (op_mode_r == MODE_BURST);
  assign reload_val = burst ? burst_beacons_r : 16'd1;
  assign hit        = tbl_rd_valid && (tbl_rd_data == id_r);

  nds_table #(
    .DEPTH (MAX_NEIGHBORS),
    .WIDTH (ID_W)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (tbl_wr_en),
    .wr_addr  (found_total_r[ADDR_W-1:0]),
    .wr_data  (id_r),
    .rd_en    (tbl_rd_en),
    .rd_addr  (idx_r[ADDR_W-1:0]),
    .rd_data  (tbl_rd_data),
    .rd_valid (tbl_rd_valid)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_mode_r        <= RST_OP_MODE;
      epoch_phases_r   <= RST_EPOCH_PHASES;
      burst_beacons_r  <= RST_BURST_BEACONS;
      beacon_spacing_r <= RST_BEACON_SPACING;
      beacon_window_r  <= RST_BEACON_WINDOW;
      listen_window_r  <= RST_LISTEN_WINDOW;
      listen_slice_r   <= RST_LISTEN_SLICE;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_OP_MODE:        op_mode_r        <= cfg_wdata[0];
        CFG_EPOCH_PHASES:   epoch_phases_r   <= cfg_wdata[15:0];
        CFG_BURST_BEACONS:  burst_beacons_r  <= cfg_wdata[15:0];
        CFG_BEACON_SPACING: beacon_spacing_r <= cfg_wdata;
        CFG_BEACON_WINDOW:  beacon_window_r  <= cfg_wdata;
        CFG_LISTEN_WINDOW:  listen_window_r  <= cfg_wdata;
        CFG_LISTEN_SLICE:   listen_slice_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Phase unit: one step of the burst or scatter sequence from the current state.
  always_comb begin
    ph_index   = phase_index_r;
    ph_beacons = beacons_left_r;
    ph_count   = 1'b0;
    ph_action  = ACT_NONE;
    ph_wait    = '0;
    if (burst) begin
      ph_kind = phase_index_r;
    end else begin
      ph_kind = (phase_index_r == 2'd2) ? PK_SEND : phase_index_r + 2'd1;
    end
    if (phase_index_r == PH_UNUSED) begin
      ph_index = '0;
    end else begin
      unique case (ph_kind)
        PK_SEND: begin
          if (beacons_left_r == '0) begin
            ph_beacons = reload_val;
            ph_count   = 1'b1;
            if (burst) begin
              ph_index = phase_index_r + 2'd1;
            end
          end else begin
            ph_beacons = beacons_left_r - 16'd1;
            ph_action  = ACT_BEACON;
            ph_wait    = burst ? beacon_spacing_r : beacon_window_r;
          end
        end
        PK_LISTEN: begin
          ph_index  = phase_index_r + 2'd1;
          ph_action = ACT_ON;
          ph_wait   = burst ? listen_slice_r : listen_window_r;
        end
        PK_END: begin
          ph_count  = 1'b1;
          ph_action = ACT_OFF;
          if (burst) begin
            ph_index = phase_index_r - 2'd1;
            // A slice longer than the window leaves no off time.
            ph_wait  = (listen_window_r > listen_slice_r) ?
                       (listen_window_r - listen_slice_r) : '0;
          end else begin
            ph_index = phase_index_r + 2'd1;
          end
        end
        default: begin
          ph_index = '0;
        end
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == OP_STEP) begin
            state_nxt = ST_STEP;
          end else if (in_data.id_ok) begin
            state_nxt = ST_SEARCH;
          end
        end
      end
      ST_STEP: begin
        state_nxt = epoch_due ? ST_PHASE : ST_IDLE;
      end
      ST_PHASE: begin
        state_nxt = ST_IDLE;
      end
      ST_SEARCH: begin
        if (hit) begin
          state_nxt = ST_IDLE;
        end else if (idx_r >= found_total_r) begin
          state_nxt = ST_NEW;
        end
      end
      ST_NEW: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Datapath and result beats
  always_comb begin
    phase_index_nxt   = phase_index_r;
    beacons_left_nxt  = beacons_left_r;
    phases_done_nxt   = phases_done_r;
    epoch_counter_nxt = epoch_counter_r;
    found_total_nxt   = found_total_r;
    idx_nxt           = idx_r;
    id_nxt            = id_r;
    out_valid_nxt     = 1'b0;
    out_data_nxt      = '0;
    tbl_wr_en         = 1'b0;
    tbl_rd_en         = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_data.op == OP_RECEIVE)) begin
          id_nxt  = in_data.neighbor_id[ID_W-1:0];
          idx_nxt = '0;
        end
      end
      ST_STEP, ST_PHASE: begin
        if ((state_r == ST_STEP) && epoch_due) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.kind         = KIND_EPOCH;
          out_data_nxt.epoch_number = epoch_counter_r;
          out_data_nxt.found_count  = 7'(found_total_r);
          epoch_counter_nxt         = epoch_counter_r + 16'd1;
          found_total_nxt           = '0;
          phases_done_nxt           = '0;
          phase_index_nxt           = '0;
          beacons_left_nxt          = reload_val;
        end else begin
          phase_index_nxt         = ph_index;
          beacons_left_nxt        = ph_beacons;
          phases_done_nxt         = phases_done_r + {15'd0, ph_count};
          out_valid_nxt           = 1'b1;
          out_data_nxt.kind       = KIND_PHASE;
          out_data_nxt.action     = ph_action;
          out_data_nxt.wait_ticks = ph_wait;
          out_data_nxt.last       = 1'b1;
        end
      end
      ST_SEARCH: begin
        // The compare of the entry read last cycle runs beside the next read.
        if (!hit && (idx_r < found_total_r)) begin
          tbl_rd_en = 1'b1;
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end
      ST_NEW: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.kind         = KIND_NEIGHBOR;
        out_data_nxt.epoch_number = epoch_counter_r;
        out_data_nxt.found_id     = 16'(id_r);
        out_data_nxt.last         = 1'b1;
        if (found_total_r == TABLE_FULL_CNT) begin
          out_data_nxt.table_full = 1'b1;
        end else begin
          tbl_wr_en       = 1'b1;
          found_total_nxt = found_total_r + CNT_W'(1);
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      phase_index_r   <= '0;
      beacons_left_r  <= RST_BURST_BEACONS;
      phases_done_r   <= '0;
      epoch_counter_r <= '0;
      found_total_r   <= '0;
      idx_r           <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      state_r         <= state_nxt;
      phase_index_r   <= phase_index_nxt;
      beacons_left_r  <= beacons_left_nxt;
      phases_done_r   <= phases_done_nxt;
      epoch_counter_r <= epoch_counter_nxt;
      found_total_r   <= found_total_nxt;
      idx_r           <= idx_nxt;
      out_valid_r     <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    id_r       <= id_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
